FILE: rtl/core/bpe_pkg.sv
package bpe_pkg;

    // Fixed field widths of the streaming payload.
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 10;
    localparam int ROW_IDX_W  = 2;
    localparam int COL_IDX_W  = 3;

    // Default patch geometry and fraction precision.
    localparam int PATCH_ROWS_DEF    = 4;
    localparam int PATCH_COLS_DEF    = 5;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [STEP_W-1:0] STEP_COUNT_RESET = STEP_W'(16);

    // Input tdata: cp_row, cp_col, cp_x, cp_y, cp_z, grid_row, grid_col, zero fill.
    localparam int S_FIELDS_W = ROW_IDX_W + COL_IDX_W + 3 * DATA_W + 2 * STEP_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 3 * DATA_W;

    localparam int CP_ROW_LSB   = 0;
    localparam int CP_COL_LSB   = CP_ROW_LSB + ROW_IDX_W;
    localparam int CP_X_LSB     = CP_COL_LSB + COL_IDX_W;
    localparam int CP_Y_LSB     = CP_X_LSB + DATA_W;
    localparam int CP_Z_LSB     = CP_Y_LSB + DATA_W;
    localparam int GRID_ROW_LSB = CP_Z_LSB + DATA_W;
    localparam int GRID_COL_LSB = GRID_ROW_LSB + STEP_W;

    // Item kinds carried in tuser.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // Per-cycle commands from the sequencer to the coordinate lanes.
    typedef struct packed {
        logic rd_en;      // read one control point from the store
        logic row_shift;  // shift the read point into the row line
        logic mul_en;     // issue one multiply for an interpolation
        logic acc_en;     // finish a step: shift the active line
        logic acc_lerp;   // the appended value is the interpolation result
        logic sel_col;    // the column line is the active line
        logic col_push;   // move the finished row result into the column line
    } lane_ctl_t;

endpackage

FILE: rtl/core/bezier_patch_point_evaluator.sv
// Throughput: an evaluation runs on a single multiplier per coordinate, and a new one is
//   accepted only once the previous result has entered the output register; loads are
//   taken one per cycle while no evaluation runs.
// Reset: aresetn is synchronous and active low; step_count returns to 16 and the
//   control point stores hold whatever was last written until reloaded.
module bezier_patch_point_evaluator
    import bpe_pkg::*;
#(
    parameter int PATCH_ROWS    = PATCH_ROWS_DEF,
    parameter int PATCH_COLS    = PATCH_COLS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    // Configuration: step_count, written whenever cfg_wr_en is high.
    input  logic                    cfg_wr_en,
    input  logic [STEP_W-1:0]       cfg_wr_data,

    // Input stream.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // From bit 0: cp_row, cp_col, cp_x, cp_y, cp_z, grid_row, grid_col, zero fill.
    input  logic [S_TDATA_W-1:0]    s_tdata,
    // Bit 0: func (0 load a control point, 1 evaluate a surface point).
    input  logic                    s_tuser,

    // Result stream.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // From bit 0: point_x, point_y, point_z.
    output logic [M_TDATA_W-1:0]    m_tdata
);

    localparam int GRID = PATCH_ROWS * PATCH_COLS;
    localparam int AW   = $clog2(GRID);

    logic [STEP_W-1:0]        step_count_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    logic                     s_accept;
    logic                     eval_accept;
    logic                     load_en;
    logic [ROW_IDX_W-1:0]     cp_row;
    logic [COL_IDX_W-1:0]     cp_col;
    logic signed [DATA_W-1:0] cp_x;
    logic signed [DATA_W-1:0] cp_y;
    logic signed [DATA_W-1:0] cp_z;
    logic [STEP_W-1:0]        grid_row;
    logic [STEP_W-1:0]        grid_col;
    logic [AW-1:0]            wr_addr;
    logic [STEP_W-1:0]        divisor;

    logic                     div_start;
    logic [STEP_W-1:0]        div_index;
    logic                     div_done;
    logic [FRACTION_BITS:0]   div_quot;
    lane_ctl_t                ctl;
    logic [AW-1:0]            rd_addr;
    logic [FRACTION_BITS:0]   frac;
    logic                     out_load;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;

    // Unpack the input transaction.
    assign cp_row   = s_tdata[CP_ROW_LSB +: ROW_IDX_W];
    assign cp_col   = s_tdata[CP_COL_LSB +: COL_IDX_W];
    assign cp_x     = s_tdata[CP_X_LSB +: DATA_W];
    assign cp_y     = s_tdata[CP_Y_LSB +: DATA_W];
    assign cp_z     = s_tdata[CP_Z_LSB +: DATA_W];
    assign grid_row = s_tdata[GRID_ROW_LSB +: STEP_W];
    assign grid_col = s_tdata[GRID_COL_LSB +: STEP_W];

    assign s_accept    = s_tvalid && s_tready;
    assign eval_accept = s_accept && (s_tuser == FUNC_EVAL);

    // A load that names a point outside the grid is dropped. Loads write the
    // stores directly in the cycle they are accepted and produce no result.
    assign load_en = s_accept && (s_tuser == FUNC_LOAD)
                  && (32'(cp_row) < PATCH_ROWS) && (32'(cp_col) < PATCH_COLS);
    assign wr_addr = AW'(32'(cp_row) * PATCH_COLS + 32'(cp_col));

    // A step count of zero behaves as one.
    assign divisor = (step_count_reg == '0) ? STEP_W'(1) : step_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= STEP_COUNT_RESET;
        end else if (cfg_wr_en) begin
            step_count_reg <= cfg_wr_data;
        end
    end

    // Output register: loaded only when the previous result has been taken,
    // so the input side stays open while a result waits.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {point_z, point_y, point_x};
        end
    end

    // One divider produces the row fraction first, then the column fraction.
    bpe_frac_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .index   (div_index),
        .divisor (divisor),
        .done    (div_done),
        .quot    (div_quot)
    );

    // The sequencer walks every row through de Casteljau at the column
    // fraction, then the row results at the row fraction.
    bpe_ctrl #(
        .PATCH_ROWS    (PATCH_ROWS),
        .PATCH_COLS    (PATCH_COLS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .eval_accept (eval_accept),
        .grid_row    (grid_row),
        .grid_col    (grid_col),
        .s_ready     (s_tready),
        .div_start   (div_start),
        .div_index   (div_index),
        .div_done    (div_done),
        .div_quot    (div_quot),
        .ctl         (ctl),
        .rd_addr     (rd_addr),
        .frac        (frac),
        .out_load    (out_load),
        .m_ready     (m_tready),
        .m_valid     (m_tvalid)
    );

    // Three identical lanes, one per coordinate, run in lockstep.
    bpe_lane #(
        .PATCH_ROWS    (PATCH_ROWS),
        .PATCH_COLS    (PATCH_COLS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_x (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (wr_addr),
        .wr_data (cp_x),
        .rd_addr (rd_addr),
        .ctl     (ctl),
        .frac    (frac),
        .result  (point_x)
    );

    bpe_lane #(
        .PATCH_ROWS    (PATCH_ROWS),
        .PATCH_COLS    (PATCH_COLS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_y (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (wr_addr),
        .wr_data (cp_y),
        .rd_addr (rd_addr),
        .ctl     (ctl),
        .frac    (frac),
        .result  (point_y)
    );

    bpe_lane #(
        .PATCH_ROWS    (PATCH_ROWS),
        .PATCH_COLS    (PATCH_COLS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_z (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (wr_addr),
        .wr_data (cp_z),
        .rd_addr (rd_addr),
        .ctl     (ctl),
        .frac    (frac),
        .result  (point_z)
    );

    assign m_tdata = m_tdata_reg;

endmodule

FILE: rtl/core/bpe_frac_div.sv
module bpe_frac_div
    import bpe_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [STEP_W-1:0]        index,
    input  logic [STEP_W-1:0]        divisor,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quot
);

    localparam int CW = $clog2(FRACTION_BITS + 1);

    logic [STEP_W-1:0]        rem_reg;
    logic [STEP_W-1:0]        div_reg;
    logic [FRACTION_BITS-1:0] q_reg;
    logic                     full_reg;
    logic                     done_reg;
    logic [CW-1:0]            cnt_reg;

    logic [STEP_W-1:0] idx_clamped;
    logic [STEP_W:0]   rem_dbl;
    logic [STEP_W:0]   rem_sub;
    logic              ge;

    // Restoring division, one quotient bit per cycle. The clamped index never
    // exceeds the divisor, so the quotient is either exactly one or below it.
    always_comb begin
        idx_clamped = (index > divisor) ? divisor : index;
        rem_dbl     = {rem_reg, 1'b0};
        rem_sub     = rem_dbl - {1'b0, div_reg};
        ge          = (rem_dbl >= {1'b0, div_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                div_reg  <= divisor;
                full_reg <= (idx_clamped == divisor);
                rem_reg  <= (idx_clamped == divisor) ? '0 : idx_clamped;
                q_reg    <= '0;
                cnt_reg  <= CW'(FRACTION_BITS);
            end else if (cnt_reg != '0) begin
                rem_reg <= ge ? rem_sub[STEP_W-1:0] : rem_dbl[STEP_W-1:0];
                q_reg   <= {q_reg[FRACTION_BITS-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = full_reg ? {1'b1, {FRACTION_BITS{1'b0}}} : {1'b0, q_reg};

endmodule

FILE: rtl/core/bpe_lane.sv
module bpe_lane
    import bpe_pkg::*;
#(
    parameter int PATCH_ROWS    = PATCH_ROWS_DEF,
    parameter int PATCH_COLS    = PATCH_COLS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [$clog2(PATCH_ROWS*PATCH_COLS)-1:0]    wr_addr,
    input  logic signed [DATA_W-1:0]                    wr_data,
    input  logic [$clog2(PATCH_ROWS*PATCH_COLS)-1:0]    rd_addr,
    input  lane_ctl_t                                   ctl,
    input  logic [FRACTION_BITS:0]                      frac,
    output logic signed [DATA_W-1:0]                    result
);

    localparam int GRID = PATCH_ROWS * PATCH_COLS;
    localparam int PW   = FRACTION_BITS + DATA_W + 3;
    localparam int QW   = PW - FRACTION_BITS;

    logic signed [DATA_W-1:0] mem [GRID];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] row_line_reg [PATCH_COLS];
    logic signed [DATA_W-1:0] col_line_reg [PATCH_ROWS];
    logic signed [DATA_W-1:0] a_reg;
    logic signed [PW-1:0]     prod_reg;

    logic signed [DATA_W-1:0] head0;
    logic signed [DATA_W-1:0] head1;
    logic signed [DATA_W:0]   diff;
    logic signed [PW-1:0]     sum;
    logic        [QW-1:0]     quo;
    logic        [QW-DATA_W:0] quo_top;
    logic signed [DATA_W-1:0] lerp_res;
    logic signed [DATA_W-1:0] acc_val;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a*(1-f) + b*f is formed as a + (b-a)*f; the product is registered and
    // the add, rounding shift and saturation follow in the next cycle.
    always_comb begin
        head0    = ctl.sel_col ? col_line_reg[0] : row_line_reg[0];
        head1    = ctl.sel_col ? col_line_reg[1] : row_line_reg[1];
        diff     = {head1[DATA_W-1], head1} - {head0[DATA_W-1], head0};
        sum      = prod_reg + (PW'(a_reg) <<< FRACTION_BITS)
                 + (PW'(1) <<< (FRACTION_BITS - 1));
        quo      = sum[PW-1:FRACTION_BITS];
        quo_top  = quo[QW-1:DATA_W-1];
        if ((quo_top == '0) || (quo_top == '1)) begin
            lerp_res = quo[DATA_W-1:0];
        end else if (quo[QW-1]) begin
            lerp_res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            lerp_res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        acc_val = ctl.acc_lerp ? lerp_res : head0;
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            a_reg    <= head0;
            prod_reg <= PW'(diff) * PW'($signed({1'b0, frac}));
        end

        // Each step drops the head of the active line and appends at its tail.
        if (ctl.row_shift || (ctl.acc_en && !ctl.sel_col)) begin
            for (int i = 0; i < PATCH_COLS - 1; i++) begin
                row_line_reg[i] <= row_line_reg[i+1];
            end
            row_line_reg[PATCH_COLS-1] <= ctl.row_shift ? rd_data_reg : acc_val;
        end

        if (ctl.col_push || (ctl.acc_en && ctl.sel_col)) begin
            for (int i = 0; i < PATCH_ROWS - 1; i++) begin
                col_line_reg[i] <= col_line_reg[i+1];
            end
            col_line_reg[PATCH_ROWS-1] <= ctl.col_push ? row_line_reg[0] : acc_val;
        end
    end

    assign result = col_line_reg[0];

endmodule

FILE: rtl/core/bpe_ctrl.sv
module bpe_ctrl
    import bpe_pkg::*;
#(
    parameter int PATCH_ROWS    = PATCH_ROWS_DEF,
    parameter int PATCH_COLS    = PATCH_COLS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        eval_accept,
    input  logic [STEP_W-1:0]                           grid_row,
    input  logic [STEP_W-1:0]                           grid_col,
    output logic                                        s_ready,
    output logic                                        div_start,
    output logic [STEP_W-1:0]                           div_index,
    input  logic                                        div_done,
    input  logic [FRACTION_BITS:0]                      div_quot,
    output lane_ctl_t                                   ctl,
    output logic [$clog2(PATCH_ROWS*PATCH_COLS)-1:0]    rd_addr,
    output logic [FRACTION_BITS:0]                      frac,
    output logic                                        out_load,
    input  logic                                        m_ready,
    output logic                                        m_valid
);

    localparam int GRID = PATCH_ROWS * PATCH_COLS;
    localparam int AW   = $clog2(GRID);
    localparam int RW   = $clog2(PATCH_ROWS);
    localparam int LW   = $clog2(PATCH_COLS + 1);
    localparam int LMAX = (PATCH_ROWS > PATCH_COLS) ? PATCH_ROWS : PATCH_COLS;
    localparam int KW   = $clog2(LMAX);
    localparam int NW   = $clog2(LMAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_V,
        ST_DIV_U,
        ST_LOAD,
        ST_STEP,
        ST_ACC,
        ST_PUSH,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [STEP_W-1:0]        col_idx_reg;
    logic [FRACTION_BITS:0]   u_reg;
    logic [FRACTION_BITS:0]   v_reg;
    logic [AW-1:0]            rd_addr_reg;
    logic [LW-1:0]            ld_cnt_reg;
    logic [RW-1:0]            row_cnt_reg;
    logic [KW-1:0]            step_reg;
    logic [NW-1:0]            lvl_reg;
    logic                     sel_col_reg;
    logic                     m_valid_reg;

    logic load_busy;
    logic is_lerp;
    logic step_last;
    logic lvl_last;
    logic step_done;
    logic out_free;

    // A level of n points always takes as many steps as the line is long:
    // the first n-1 interpolate, the rest only rotate, so the results end up
    // at the head of the line.
    always_comb begin
        load_busy = (ld_cnt_reg != LW'(PATCH_COLS));
        is_lerp   = (NW'(step_reg) < (lvl_reg - NW'(1)));
        step_last = sel_col_reg ? (step_reg == KW'(PATCH_ROWS - 1))
                                : (step_reg == KW'(PATCH_COLS - 1));
        lvl_last  = (lvl_reg == NW'(2));
        step_done = (state_reg == ST_ACC) || ((state_reg == ST_STEP) && !is_lerp);
        out_free  = !m_valid_reg || m_ready;

        ctl           = '0;
        ctl.sel_col   = sel_col_reg;
        ctl.rd_en     = (state_reg == ST_LOAD) && load_busy;
        ctl.row_shift = (state_reg == ST_LOAD) && (ld_cnt_reg != '0);
        ctl.mul_en    = (state_reg == ST_STEP) && is_lerp;
        ctl.acc_en    = step_done;
        ctl.acc_lerp  = (state_reg == ST_ACC);
        ctl.col_push  = (state_reg == ST_PUSH);

        div_start = ((state_reg == ST_IDLE) && eval_accept)
                 || ((state_reg == ST_DIV_V) && div_done);
        div_index = (state_reg == ST_IDLE) ? grid_row : col_idx_reg;
        out_load  = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            sel_col_reg <= 1'b0;
            rd_addr_reg <= '0;
            ld_cnt_reg  <= '0;
            row_cnt_reg <= '0;
            step_reg    <= '0;
            lvl_reg     <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (ctl.rd_en) begin
                rd_addr_reg <= rd_addr_reg + AW'(1);
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (eval_accept) begin
                        col_idx_reg <= grid_col;
                        rd_addr_reg <= '0;
                        state_reg   <= ST_DIV_V;
                    end
                end
                ST_DIV_V: begin
                    if (div_done) begin
                        v_reg     <= div_quot;
                        state_reg <= ST_DIV_U;
                    end
                end
                ST_DIV_U: begin
                    if (div_done) begin
                        u_reg       <= div_quot;
                        row_cnt_reg <= '0;
                        ld_cnt_reg  <= '0;
                        sel_col_reg <= 1'b0;
                        state_reg   <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (load_busy) begin
                        ld_cnt_reg <= ld_cnt_reg + LW'(1);
                    end else begin
                        lvl_reg   <= NW'(PATCH_COLS);
                        step_reg  <= '0;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP, ST_ACC: begin
                    if (state_reg == ST_STEP && is_lerp) begin
                        state_reg <= ST_ACC;
                    end else if (step_last) begin
                        step_reg <= '0;
                        if (lvl_last) begin
                            state_reg <= sel_col_reg ? ST_OUT : ST_PUSH;
                        end else begin
                            lvl_reg   <= lvl_reg - NW'(1);
                            state_reg <= ST_STEP;
                        end
                    end else begin
                        step_reg  <= step_reg + KW'(1);
                        state_reg <= ST_STEP;
                    end
                end
                ST_PUSH: begin
                    if (row_cnt_reg == RW'(PATCH_ROWS - 1)) begin
                        sel_col_reg <= 1'b1;
                        lvl_reg     <= NW'(PATCH_ROWS);
                        step_reg    <= '0;
                        state_reg   <= ST_STEP;
                    end else begin
                        row_cnt_reg <= row_cnt_reg + RW'(1);
                        ld_cnt_reg  <= '0;
                        state_reg   <= ST_LOAD;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign rd_addr = rd_addr_reg;
    assign frac    = sel_col_reg ? v_reg : u_reg;
    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/core/bpe_checker.sv
module bpe_checker
    import bpe_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // A stalled result holds its data.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // An evaluation closes the input side while it runs.
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_EVAL) |=> !s_tready)
        else $error("input accepted during an evaluation");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a load");

    // The input side reopens in the same cycle a new result appears.
    a_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result posted while the input side is closed");

endmodule

bind bezier_patch_point_evaluator bpe_checker u_bpe_checker (.*);
